// ===== sv/pwr_pkg.sv =====
// pwr_pkg: widths, limits and shared types of the fixed-point power block
// no dependencies; imported by pwr_fxmul, pwr_div and the top level
`timescale 1ns / 1ps

package pwr_pkg;

    localparam int EXP_WIDTH = 16;
    localparam int FRAC_BITS = 16;

    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int QUO_W      = 2 * FRAC_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] FX_ONE  = VAL_W'(64'd1 << FRAC_BITS);

    localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(VAL_MAX);
    localparam logic signed [PROD_W-1:0] WIDE_MIN = PROD_W'(VAL_MIN);

    // magnitude of the most negative value, the largest quotient a negative result takes
    localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'd1 << (VAL_W - 1));
    localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'((64'd1 << (VAL_W - 1)) - 64'd1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    sat;
    } mul_res_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_res_t;

endpackage

// ===== sv/integer_power_by_squaring_top.sv =====
// integer_power_by_squaring_top: square-and-multiply sequencer over one shared
// fixed-point multiplier, with a reciprocal divider; uses pwr_pkg, pwr_fxmul, pwr_div
`timescale 1ns / 1ps
//
//  channel   ports                                    handshake
//  ------    -----------------------------------      ------------------------------
//  input     base_value[31:0], exponent[15:0]         taken when start && !busy
//  result    result_value[31:0], overflow,            done high for one cycle,
//            divide_by_zero                           receiver cannot stall
//
//  one word at a time; busy stays high from the accept until the done cycle
//  the multiply loop scans the magnitude bit by bit, with an accumulate write-back per set
//  bit and a squaring write-back while higher bits remain, then one finish state
//  a negative exponent adds a pass through the one-bit-a-cycle divider
//  reset clears the sequencer and the divider control; no clearing pass is needed
//  a new word may be taken in the same cycle as done

module integer_power_by_squaring_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pwr_pkg::VAL_W-1:0]     base_value,
    input  logic signed [pwr_pkg::EXP_WIDTH-1:0] exponent,
    output logic                                done,
    output logic signed [pwr_pkg::VAL_W-1:0]     result_value,
    output logic                                overflow,
    output logic                                divide_by_zero
);
    import pwr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_ACC_WB = 6'b000100,
        S_SQ_WB  = 6'b001000,
        S_FIN    = 6'b010000,
        S_DIV    = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic signed [VAL_W-1:0] base_reg;
    logic signed [VAL_W-1:0] base_next;
    logic signed [VAL_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] acc_next;
    logic [EXP_WIDTH-1:0]    mag_reg;
    logic [EXP_WIDTH-1:0]    mag_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic signed [VAL_W-1:0] result_reg;
    logic signed [VAL_W-1:0] result_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    dz_reg;
    logic                    dz_next;
    logic                    done_reg;
    logic                    done_next;

    logic [EXP_WIDTH-1:0]    mag_in;
    logic [EXP_WIDTH-1:0]    mag_shr;
    logic signed [VAL_W-1:0] mul_a;
    mul_res_t                mul_res;
    logic                    div_start;
    logic [VAL_W-1:0]        div_den;
    div_res_t                div_res;
    logic [PROD_W-1:0]       q_wide;

    // two's complement magnitude; the most negative exponent maps to its own bit pattern
    assign mag_in  = exponent[EXP_WIDTH-1] ? EXP_WIDTH'(-exponent) : EXP_WIDTH'(exponent);
    assign mag_shr = mag_reg >> 1;

    // multiply acc by base when the scanned bit is set, otherwise square the base
    assign mul_a = (state_reg == S_SCAN && mag_reg[0]) ? acc_reg : base_reg;

    pwr_fxmul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (base_reg),
        .res (mul_res)
    );

    assign div_den = acc_reg[VAL_W-1] ? VAL_W'(-acc_reg) : VAL_W'(acc_reg);
    assign q_wide  = PROD_W'(div_res.quotient);

    pwr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .res   (div_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        result_next = result_reg;
        ovf_next    = ovf_reg;
        dz_next     = dz_reg;
        done_next   = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_next  = base_value;
                    acc_next   = FX_ONE;
                    mag_next   = mag_in;
                    neg_next   = exponent[EXP_WIDTH-1];
                    sat_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mag_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (mag_reg[0])
                begin
                    state_next = S_ACC_WB;
                end
                else
                begin
                    // bit clear and higher bits remain: squaring is under way
                    mag_next   = mag_shr;
                    state_next = S_SQ_WB;
                end
            end
            S_ACC_WB:
            begin
                acc_next = mul_res.value;
                sat_next = sat_reg | mul_res.sat;
                mag_next = mag_shr;
                if (mag_shr != '0)
                begin
                    state_next = S_SQ_WB;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SQ_WB:
            begin
                base_next  = mul_res.value;
                sat_next   = sat_reg | mul_res.sat;
                state_next = S_SCAN;
            end
            S_FIN:
            begin
                if (!neg_reg)
                begin
                    result_next = acc_reg;
                    ovf_next    = sat_reg;
                    dz_next     = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (acc_reg == '0)
                begin
                    result_next = VAL_MAX;
                    ovf_next    = sat_reg;
                    dz_next     = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    dz_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    priority if (acc_reg[VAL_W-1] && q_wide > NEG_LIMIT)
                    begin
                        result_next = VAL_MIN;
                        ovf_next    = 1'b1;
                    end
                    else if (!acc_reg[VAL_W-1] && q_wide > POS_LIMIT)
                    begin
                        result_next = VAL_MAX;
                        ovf_next    = 1'b1;
                    end
                    else
                    begin
                        result_next = acc_reg[VAL_W-1] ? VAL_W'(PROD_W'(0) - q_wide)
                                                       : VAL_W'(q_wide);
                        ovf_next    = sat_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        result_reg <= result_next;
        ovf_reg    <= ovf_next;
        dz_reg     <= dz_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_value   = result_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without work in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (result_value == VAL_MAX))
        else $error("divide by zero without saturated result");

    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && exponent == '0) |-> ##3
            (done && result_value == FX_ONE && !overflow && !divide_by_zero))
        else $error("zero exponent did not give one");
`endif

endmodule

// ===== sv/pwr_fxmul.sv =====
// pwr_fxmul: shared fixed-point multiplier with registered product,
// arithmetic shift by the fraction bits and saturation; uses pwr_pkg
`timescale 1ns / 1ps

module pwr_fxmul (
    input  logic                            clk,
    input  logic signed [pwr_pkg::VAL_W-1:0] a,
    input  logic signed [pwr_pkg::VAL_W-1:0] b,
    output pwr_pkg::mul_res_t               res
);
    import pwr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] shifted;

    always_comb
    begin
        prod_next = PROD_W'(a) * PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // shift rounds toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        priority if (shifted > WIDE_MAX)
        begin
            res.value = VAL_MAX;
            res.sat   = 1'b1;
        end
        else if (shifted < WIDE_MIN)
        begin
            res.value = VAL_MIN;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = VAL_W'(shifted);
            res.sat   = 1'b0;
        end
    end

endmodule

// ===== sv/pwr_div.sv =====
// pwr_div: restoring divider, one quotient bit a cycle, of the constant
// one-squared numerator by a 32-bit magnitude; uses pwr_pkg
`timescale 1ns / 1ps

module pwr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pwr_pkg::VAL_W-1:0]  den,
    output pwr_pkg::div_res_t          res
);
    import pwr_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [VAL_W-1:0]     rem_reg;
    logic [VAL_W-1:0]     rem_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [VAL_W-1:0]     den_reg;
    logic [VAL_W-1:0]     den_next;
    logic                 num_bit;
    logic [VAL_W:0]       trial;
    logic [VAL_W:0]       den_wide;
    logic                 ge;

    // the numerator has a single set bit, at position 2*FRAC_BITS
    assign num_bit  = (cnt_reg == DIV_CNT_W'(2 * FRAC_BITS));
    assign trial    = {rem_reg, num_bit};
    assign den_wide = {1'b0, den_reg};
    assign ge       = (trial >= den_wide);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUO_W - 1);
            rem_next  = '0;
            quo_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VAL_W'(trial - den_wide) : trial[VAL_W-1:0];
            quo_next = QUO_W'({quo_reg, ge});
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule
